>>> rtl/core/trilinear_volume_sampler_top_defines.svh
// Assertion macros shared by the trilinear volume sampler RTL.
`ifndef TRILINEAR_VOLUME_SAMPLER_TOP_DEFINES_SVH
`define TRILINEAR_VOLUME_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define TVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define TVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tvs_pkg.sv
// Shared types, constants and codes of the trilinear volume sampler.
`timescale 1ns / 1ps

package tvs_pkg;

	// Grid and number format.
	localparam int DIM_BITS    = 5;
	localparam int FRAC_BITS   = 8;
	localparam int VALUE_BITS  = 16;

	localparam int SIZE_W      = DIM_BITS + 1;
	localparam int ADDR_W      = 3 * DIM_BITS;
	localparam int POS_W       = DIM_BITS + FRAC_BITS;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int GRID_MAX    = 1 << DIM_BITS;
	localparam int SIZE_MIN    = 2;
	localparam int PROD_W      = VALUE_BITS + FRAC_BITS + 2;

	// Configuration port.
	localparam int DATA_W      = 32;
	localparam int PADDR_W     = 4;

	typedef logic [SIZE_W-1:0]            size_t;
	typedef logic [DIM_BITS-1:0]          dim_t;
	typedef logic [FRAC_BITS-1:0]         frac_t;
	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [POS_W-1:0]             pos_t;
	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [1:0]                   reg_idx_t;
	typedef logic [2:0]                   tag_t;

	// Item commands.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Register indexes.
	localparam reg_idx_t REG_SIZE_X = 2'd0;
	localparam reg_idx_t REG_SIZE_Y = 2'd1;
	localparam reg_idx_t REG_SIZE_Z = 2'd2;

	// Destination of an interpolation result.
	localparam tag_t TAG_C00 = 3'd0;
	localparam tag_t TAG_C01 = 3'd1;
	localparam tag_t TAG_C10 = 3'd2;
	localparam tag_t TAG_C11 = 3'd3;
	localparam tag_t TAG_C0  = 3'd4;
	localparam tag_t TAG_C1  = 3'd5;
	localparam tag_t TAG_C   = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADDR,
		ST_BASE,
		ST_FETCH,
		ST_XWAIT,
		ST_YLO,
		ST_YHI,
		ST_YWAIT,
		ST_Z
	} state_t;

	// Request to and result from the interpolation unit.
	typedef struct packed {
		logic   go;
		tag_t   tag;
		value_t a;
		value_t b;
		frac_t  f;
	} lerp_req_t;

	typedef struct packed {
		logic   vld;
		tag_t   tag;
		value_t value;
	} lerp_rsp_t;

endpackage

>>> rtl/core/tvs_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface tvs_in_if;
	import tvs_pkg::*;

	logic   valid;
	logic   ready;
	logic   command;
	addr_t  voxel_index;
	value_t voxel_value;
	pos_t   pos_x;
	pos_t   pos_y;
	pos_t   pos_z;

	modport source (
		output valid, command, voxel_index, voxel_value, pos_x, pos_y, pos_z,
		input  ready
	);

	modport sink (
		input  valid, command, voxel_index, voxel_value, pos_x, pos_y, pos_z,
		output ready
	);
endinterface

interface tvs_out_if;
	import tvs_pkg::*;

	logic   valid;
	logic   ready;
	value_t sample_value;
	logic   out_of_range;

	modport source (
		output valid, sample_value, out_of_range,
		input  ready
	);

	modport sink (
		input  valid, sample_value, out_of_range,
		output ready
	);
endinterface

>>> rtl/core/trilinear_volume_sampler_top.sv
// Trilinear volume sampler top level: voxel store, corner sequencer, result register.
// Write items are accepted back to back.
// A sample blocks new input until its final step is issued: eight corner reads
// through the single-port voxel store overlap the x round, then the y and z rounds run.
// All rounds share the one interpolator; a full output register stalls the last step.
// Reset clears control state and sets all sizes to 32; the voxel store is not cleared.
`timescale 1ns / 1ps
`include "trilinear_volume_sampler_top_defines.svh"

module trilinear_volume_sampler_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tvs_pkg::PADDR_W-1:0] paddr,
	input  logic [tvs_pkg::DATA_W-1:0]  pwdata,
	output logic [tvs_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	tvs_in_if.sink                      in_ch,
	tvs_out_if.source                   out_ch
);
	import tvs_pkg::*;

	// Grid size registers.
	size_t     size_x_q;
	size_t     size_y_q;
	size_t     size_z_q;
	reg_idx_t  reg_idx;

	// Control.
	state_t    state_q;
	state_t    state_d;
	logic      in_accept;
	logic [2:0] rd_cnt_q;
	logic      rd_vld_s1;
	logic [2:0] rd_n_s1;
	logic      out_valid_q;

	// Sample setup.
	dim_t      ix_q, iy_q, iz_q;
	frac_t     fx_q, fy_q, fz_q;
	size_t     sx_q;
	logic [2*SIZE_W-1:0] sxy_q;
	dim_t      i0_q, i1_q, j0_q, j1_q, k0_q, k1_q;
	logic      flag_q;
	addr_t     kb0_q, kb1_q, jb0_q, jb1_q;
	logic [DIM_BITS+2*SIZE_W-1:0] kmul0, kmul1;
	logic [DIM_BITS+SIZE_W-1:0]   jmul0, jmul1;
	size_t     sx_e, sy_e, sz_e;
	size_t     lim_x, lim_y, lim_z;
	size_t     up_x0, up_x1, up_y0, up_y1, up_z0, up_z1;

	// Voxel store.
	logic [VALUE_BITS-1:0] mem [STORE_DEPTH];
	logic      mem_we;
	addr_t     mem_addr;
	addr_t     corner_addr;
	logic [VALUE_BITS-1:0] rd_data_q;
	value_t    a_q;

	// Interpolation.
	lerp_req_t lerp_req;
	lerp_rsp_t lerp_rsp;
	value_t    c00_q, c01_q, c10_q, c11_q, c0_q, c1_q;
	value_t    sample_value_q;
	logic      out_of_range_q;

	function automatic size_t eff_size(input size_t s);
		size_t r;
		r = s;
		if (s < size_t'(SIZE_MIN)) begin
			r = size_t'(SIZE_MIN);
		end else if (s > size_t'(GRID_MAX)) begin
			r = size_t'(GRID_MAX);
		end
		return r;
	endfunction

	// Configuration port: pready is tied high, reads return the stored sizes.
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_comb begin
		case (reg_idx)
			REG_SIZE_X: prdata = DATA_W'(size_x_q);
			REG_SIZE_Y: prdata = DATA_W'(size_y_q);
			REG_SIZE_Z: prdata = DATA_W'(size_z_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= size_t'(GRID_MAX);
			size_y_q <= size_t'(GRID_MAX);
			size_z_q <= size_t'(GRID_MAX);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_SIZE_X: size_x_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_Y: size_y_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_Z: size_z_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: next state, input handshake and interpolator requests.
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		lerp_req    = '0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid && in_ch.command == CMD_SAMPLE) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				state_d = ST_BASE;
			end
			ST_BASE: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				if (rd_cnt_q == 3'd7) begin
					state_d = ST_XWAIT;
				end
			end
			ST_XWAIT: begin
				if (lerp_rsp.vld && lerp_rsp.tag == TAG_C11) begin
					state_d = ST_YLO;
				end
			end
			ST_YLO: begin
				lerp_req = '{go: 1'b1, tag: TAG_C0, a: c00_q, b: c10_q, f: fy_q};
				state_d  = ST_YHI;
			end
			ST_YHI: begin
				lerp_req = '{go: 1'b1, tag: TAG_C1, a: c01_q, b: c11_q, f: fy_q};
				state_d  = ST_YWAIT;
			end
			ST_YWAIT: begin
				if (lerp_rsp.vld && lerp_rsp.tag == TAG_C1) begin
					state_d = ST_Z;
				end
			end
			ST_Z: begin
				// The final step waits until the output register is free.
				if (!out_valid_q || out_ch.ready) begin
					lerp_req = '{go: 1'b1, tag: TAG_C, a: c0_q, b: c1_q, f: fz_q};
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Each odd corner beat closes an x pair, sent as soon as its data returns.
		if (rd_vld_s1 && rd_n_s1[0]) begin
			lerp_req = '{go: 1'b1, tag: tag_t'({1'b0, rd_n_s1[2:1]}), a: a_q,
				b: $signed(rd_data_q), f: fx_q};
		end
	end

	assign in_accept = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_n_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_FETCH);
			rd_n_s1   <= rd_cnt_q;
			if (state_q == ST_FETCH) begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
			end
			if (lerp_rsp.vld && lerp_rsp.tag == TAG_C) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the sample position at acceptance.
	always_ff @(posedge clk) begin
		if (in_accept && in_ch.command == CMD_SAMPLE) begin
			ix_q <= in_ch.pos_x[POS_W-1:FRAC_BITS];
			iy_q <= in_ch.pos_y[POS_W-1:FRAC_BITS];
			iz_q <= in_ch.pos_z[POS_W-1:FRAC_BITS];
			fx_q <= in_ch.pos_x[FRAC_BITS-1:0];
			fy_q <= in_ch.pos_y[FRAC_BITS-1:0];
			fz_q <= in_ch.pos_z[FRAC_BITS-1:0];
		end
	end

	// Effective sizes and corner indices clamped to the last voxel of each axis.
	always_comb begin
		sx_e  = eff_size(size_x_q);
		sy_e  = eff_size(size_y_q);
		sz_e  = eff_size(size_z_q);
		lim_x = sx_e - size_t'(1);
		lim_y = sy_e - size_t'(1);
		lim_z = sz_e - size_t'(1);
		up_x0 = {1'b0, ix_q};
		up_y0 = {1'b0, iy_q};
		up_z0 = {1'b0, iz_q};
		up_x1 = up_x0 + size_t'(1);
		up_y1 = up_y0 + size_t'(1);
		up_z1 = up_z0 + size_t'(1);
		kmul0 = k0_q * sxy_q;
		kmul1 = k1_q * sxy_q;
		jmul0 = j0_q * sx_q;
		jmul1 = j1_q * sx_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			sx_q   <= sx_e;
			sxy_q  <= sx_e * sy_e;
			i0_q   <= (up_x0 > lim_x) ? lim_x[DIM_BITS-1:0] : up_x0[DIM_BITS-1:0];
			i1_q   <= (up_x1 > lim_x) ? lim_x[DIM_BITS-1:0] : up_x1[DIM_BITS-1:0];
			j0_q   <= (up_y0 > lim_y) ? lim_y[DIM_BITS-1:0] : up_y0[DIM_BITS-1:0];
			j1_q   <= (up_y1 > lim_y) ? lim_y[DIM_BITS-1:0] : up_y1[DIM_BITS-1:0];
			k0_q   <= (up_z0 > lim_z) ? lim_z[DIM_BITS-1:0] : up_z0[DIM_BITS-1:0];
			k1_q   <= (up_z1 > lim_z) ? lim_z[DIM_BITS-1:0] : up_z1[DIM_BITS-1:0];
			flag_q <= (up_x0 > lim_x) || (up_x1 > lim_x) || (up_y0 > lim_y)
				|| (up_y1 > lim_y) || (up_z0 > lim_z) || (up_z1 > lim_z);
		end
		if (state_q == ST_BASE) begin
			kb0_q <= kmul0[ADDR_W-1:0];
			kb1_q <= kmul1[ADDR_W-1:0];
			jb0_q <= ADDR_W'(jmul0);
			jb1_q <= ADDR_W'(jmul1);
		end
	end

	// Corner beat n: bit 0 picks the x corner, bit 1 the z corner, bit 2 the y corner.
	assign corner_addr = (rd_cnt_q[1] ? kb1_q : kb0_q) + (rd_cnt_q[2] ? jb1_q : jb0_q)
		+ ADDR_W'(rd_cnt_q[0] ? i1_q : i0_q);

	assign mem_we   = in_accept && in_ch.command == CMD_WRITE;
	assign mem_addr = (state_q == ST_FETCH) ? corner_addr : in_ch.voxel_index;

	// Single-port voxel store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= in_ch.voxel_value;
		end
		rd_data_q <= mem[mem_addr];
	end

	// Hold the even corner of each x pair.
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !rd_n_s1[0]) begin
			a_q <= $signed(rd_data_q);
		end
	end

	tvs_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lerp_req),
		.rsp    (lerp_rsp)
	);

	// Park interpolation results by destination.
	always_ff @(posedge clk) begin
		if (lerp_rsp.vld) begin
			case (lerp_rsp.tag)
				TAG_C00: c00_q          <= lerp_rsp.value;
				TAG_C01: c01_q          <= lerp_rsp.value;
				TAG_C10: c10_q          <= lerp_rsp.value;
				TAG_C11: c11_q          <= lerp_rsp.value;
				TAG_C0:  c0_q           <= lerp_rsp.value;
				TAG_C1:  c1_q           <= lerp_rsp.value;
				TAG_C:   sample_value_q <= lerp_rsp.value;
				default: ;
			endcase
		end
		if (state_q == ST_Z && lerp_req.go) begin
			out_of_range_q <= flag_q;
		end
	end

	// Result channel.
	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample_value = sample_value_q;
	assign out_ch.out_of_range = out_of_range_q;

	// A pending result is never overwritten by the next one.
	`TVS_ASSERT_NOW(a_no_result_overwrite, lerp_rsp.vld && lerp_rsp.tag == TAG_C, !out_valid_q || out_ch.ready, "result register overwritten before its beat was taken")
	// Corner pair results only arrive during the fetch phase or the wait that follows it.
	`TVS_ASSERT_NOW(a_x_result_in_fetch, lerp_rsp.vld && lerp_rsp.tag <= TAG_C11, state_q == ST_FETCH || state_q == ST_XWAIT, "x interpolation result outside the fetch phase")
	// A result appears only after the final interpolation step.
	`TVS_ASSERT_NOW(a_valid_from_final_step, $rose(out_valid_q), $past(lerp_rsp.vld && lerp_rsp.tag == TAG_C), "result valid without a final interpolation")
	// After the address step comes the base step, in which the store is not written.
	`TVS_ASSERT_NEXT(a_no_write_in_sample, state_q == ST_ADDR, !mem_we && state_q == ST_BASE, "voxel store written during a sample")

endmodule

>>> rtl/core/tvs_lerp.sv
// Two-stage rounded linear interpolation unit: a + round((b - a) * f / 2^F).
`timescale 1ns / 1ps

module tvs_lerp (
	input  logic               clk,
	input  logic               arst_n,
	input  tvs_pkg::lerp_req_t req,
	output tvs_pkg::lerp_rsp_t rsp
);
	import tvs_pkg::*;

	logic signed [VALUE_BITS:0]   a_ext;
	logic signed [VALUE_BITS:0]   b_ext;
	logic signed [VALUE_BITS:0]   diff;
	logic signed [FRAC_BITS:0]    f_ext;
	logic signed [PROD_W-1:0]     prod;
	logic signed [PROD_W-1:0]     prod_s1;
	logic signed [PROD_W-1:0]     rounded;
	logic signed [VALUE_BITS+1:0] step;
	logic signed [VALUE_BITS+1:0] sum;
	value_t                       a_s1;
	tag_t                         tag_s1;
	logic                         vld_s1;

	// Stage one: difference times the fraction.
	always_comb begin
		a_ext = {req.a[VALUE_BITS-1], req.a};
		b_ext = {req.b[VALUE_BITS-1], req.b};
		diff  = b_ext - a_ext;
		f_ext = $signed({1'b0, req.f});
		prod  = diff * f_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.go;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			prod_s1 <= prod;
			a_s1    <= req.a;
			tag_s1  <= req.tag;
		end
	end

	// Stage two: round half up, floor by the fraction width, add the base.
	// The result always lies between a and b, so it fits the value width.
	always_comb begin
		rounded   = prod_s1 + PROD_W'(1 << (FRAC_BITS - 1));
		step      = $signed(rounded[PROD_W-1:FRAC_BITS]);
		sum       = $signed({a_s1[VALUE_BITS-1], a_s1[VALUE_BITS-1], a_s1}) + step;
		rsp.vld   = vld_s1;
		rsp.tag   = tag_s1;
		rsp.value = $signed(sum[VALUE_BITS-1:0]);
	end

endmodule
